// ----- rtl/hfsc_pkg.sv -----
package hfsc_pkg;

	// Temperature span of the converter, in degrees, at full-scale code
	localparam int unsigned DEG_SPAN = 500;

	localparam int TEMP_W = 9;
	localparam int DUTY_W = 7;
	localparam int LEVEL_W = 3;

	localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_AUTO_ENABLE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_MANUAL_SPEED = 1'b1;

	typedef enum logic [LEVEL_W-1:0] {
		LVL_NORMAL   = 3'd0,
		LVL_LOW      = 3'd1,
		LVL_MEDIUM   = 3'd2,
		LVL_HIGH     = 3'd3,
		LVL_CRITICAL = 3'd4
	} level_t;

	// Result of one level update
	typedef struct packed {
		level_t             level;
		logic [DUTY_W-1:0]  duty;
	} step_t;

	// Degrees at or above which the fan climbs out of the given level
	function automatic logic [TEMP_W-1:0] up_deg(input level_t lv);
		case (lv)
			LVL_NORMAL: up_deg = 9'd25;
			LVL_LOW:    up_deg = 9'd30;
			LVL_MEDIUM: up_deg = 9'd35;
			LVL_HIGH:   up_deg = 9'd40;
			default:    up_deg = 9'd511;
		endcase
	endfunction

	// Degrees below which the fan drops out of the given level
	function automatic logic [TEMP_W-1:0] down_deg(input level_t lv);
		case (lv)
			LVL_LOW:      down_deg = 9'd24;
			LVL_MEDIUM:   down_deg = 9'd29;
			LVL_HIGH:     down_deg = 9'd34;
			LVL_CRITICAL: down_deg = 9'd39;
			default:      down_deg = 9'd0;
		endcase
	endfunction

	// Duty percent for each level
	function automatic logic [DUTY_W-1:0] level_duty(input level_t lv);
		case (lv)
			LVL_NORMAL: level_duty = 7'd0;
			LVL_LOW:    level_duty = 7'd30;
			LVL_MEDIUM: level_duty = 7'd50;
			LVL_HIGH:   level_duty = 7'd75;
			default:    level_duty = 7'd100;
		endcase
	endfunction

endpackage

// ----- rtl/hfsc_if.sv -----
// Sample channel: one converter code per request
interface hfsc_sample_if #(parameter int ADC_BITS = 10);
	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] adc_sample;

	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

// Result channel: fan duty, level and temperature per request
interface hfsc_result_if;
	logic       valid;
	logic       ready;
	logic [6:0] fan_percent;
	logic [2:0] fan_level;
	logic [8:0] temp_degrees;

	modport source (output valid, output fan_percent, output fan_level,
		output temp_degrees, input ready);
	modport sink (input valid, input fan_percent, input fan_level,
		input temp_degrees, output ready);
endinterface

// ----- rtl/hfsc_temp_scale.sv -----
// floor(sample * 500 / (2^ADC_BITS - 1)) without a divider.
// x / (2^N - 1): take q0 = x >> N, fold the remainder (x mod 2^N) + q0,
// fold once more, then one compare against full scale.
module hfsc_temp_scale #(
	parameter int ADC_BITS = 10
) (
	input  logic [ADC_BITS-1:0]       sample,
	output logic [hfsc_pkg::TEMP_W-1:0] temp
);
	import hfsc_pkg::*;

	localparam int SCALED_W = ADC_BITS + TEMP_W;
	localparam int RW = ((ADC_BITS > TEMP_W) ? ADC_BITS : TEMP_W) + 1;
	localparam int R2W = ADC_BITS + 1;
	localparam logic [ADC_BITS-1:0] FS = '1;

	logic [SCALED_W-1:0]      scaled;
	logic [TEMP_W-1:0]        q0;
	logic [RW-1:0]            r1;
	logic [RW-ADC_BITS-1:0]   q1;
	logic [R2W-1:0]           r2;
	logic                     corr;

	// sample * 500 stays below 500 * 2^N, so q0 fits the degree width
	assign scaled = SCALED_W'(sample) * SCALED_W'(DEG_SPAN);
	assign q0 = scaled[SCALED_W-1:ADC_BITS];

	// first fold
	assign r1 = RW'(scaled[ADC_BITS-1:0]) + RW'(q0);
	assign q1 = r1[RW-1:ADC_BITS];

	// second fold leaves at most one full scale to remove
	assign r2 = R2W'(r1[ADC_BITS-1:0]) + R2W'(q1);
	assign corr = (r2 >= R2W'(FS));

	assign temp = q0 + TEMP_W'(q1) + TEMP_W'(corr);

endmodule

// ----- rtl/hfsc_level_step.sv -----
// One hysteresis step: move at most one level, then pick the duty
module hfsc_level_step (
	input  hfsc_pkg::level_t                cur_level,
	input  logic [hfsc_pkg::TEMP_W-1:0]     temp,
	input  logic                            auto_enable,
	input  logic [hfsc_pkg::DUTY_W-1:0]     manual_speed,
	output hfsc_pkg::step_t                 step
);
	import hfsc_pkg::*;

	level_t lv_in;
	level_t lv_next;
	logic   go_down;
	logic   go_up;

	// an out-of-range code is handled as critical
	assign lv_in = (cur_level > LVL_CRITICAL) ? LVL_CRITICAL : cur_level;

	assign go_down = (lv_in != LVL_NORMAL) && (temp < down_deg(lv_in));
	assign go_up = (lv_in != LVL_CRITICAL) && (temp >= up_deg(lv_in));

	always_comb begin
		if (go_down) begin
			lv_next = level_t'(lv_in - LEVEL_W'(1));
		end else if (go_up) begin
			lv_next = level_t'(lv_in + LEVEL_W'(1));
		end else begin
			lv_next = lv_in;
		end
	end

	// duty: level table in auto mode, clamped manual speed otherwise
	always_comb begin
		step.level = lv_next;
		if (auto_enable) begin
			step.duty = level_duty(lv_next);
		end else if (manual_speed > DUTY_MAX) begin
			step.duty = DUTY_MAX;
		end else begin
			step.duty = manual_speed;
		end
	end

endmodule

// ----- rtl/hysteresis_fan_speed_controller_unit.sv -----
// Throughput: one sample per cycle while result_out.ready does not stall the result
// register; input register, then temperature scaling and the one-level hysteresis
// update in logic, then the result register. Reset (arst_n low, asynchronous):
// pipeline empty, level normal, auto_enable 1, manual_speed 0.
module hysteresis_fan_speed_controller_unit #(
	parameter int ADC_BITS = 10
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	hfsc_sample_if.sink                          sample_in,
	hfsc_result_if.source                        result_out,
	input  logic                                 cfg_we,
	input  logic [hfsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [hfsc_pkg::DUTY_W-1:0]          cfg_wdata
);
	import hfsc_pkg::*;

	logic                  valid_s1;
	logic [ADC_BITS-1:0]   sample_s1;
	logic                  valid_s2;
	logic [DUTY_W-1:0]     percent_s2;
	level_t                level_s2;
	logic [TEMP_W-1:0]     temp_s2;

	level_t                level_q;
	logic                  auto_enable_q;
	logic [DUTY_W-1:0]     manual_speed_q;

	logic                  adv_s2;
	logic                  adv_s1;
	logic [TEMP_W-1:0]     temp;
	step_t                 step;

	// stall control: result register loads when empty or being drained
	assign adv_s2 = !valid_s2 || result_out.ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign sample_in.ready = adv_s1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_enable_q <= 1'b1;
			manual_speed_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_AUTO_ENABLE:  auto_enable_q <= cfg_wdata[0];
				CFG_MANUAL_SPEED: manual_speed_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= sample_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && sample_in.valid) begin
			sample_s1 <= sample_in.adc_sample;
		end
	end

	hfsc_temp_scale #(
		.ADC_BITS (ADC_BITS)
	) u_temp_scale (
		.sample (sample_s1),
		.temp   (temp)
	);

	hfsc_level_step u_level_step (
		.cur_level    (level_q),
		.temp         (temp),
		.auto_enable  (auto_enable_q),
		.manual_speed (manual_speed_q),
		.step         (step)
	);

	// level state moves only when a sample passes into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LVL_NORMAL;
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				level_q <= step.level;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			percent_s2 <= step.duty;
			level_s2 <= step.level;
			temp_s2 <= temp;
		end
	end

	assign result_out.valid = valid_s2;
	assign result_out.fan_percent = percent_s2;
	assign result_out.fan_level = level_s2;
	assign result_out.temp_degrees = temp_s2;

endmodule
